// File: hdl/lpfr_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the length-prefixed frame receiver
// no dependencies

package lpfr_pkg;

    localparam int MAX_FRAME = 128;
    localparam logic [7:0] MIN_LEN = 8'd6;
    localparam logic [7:0] MAX_LEN = 8'd120;

    localparam logic [6:0] OFS_TARGET  = 7'd1;
    localparam logic [6:0] OFS_SOURCE  = 7'd2;
    localparam logic [6:0] OFS_COMMAND = 7'd3;
    localparam logic [6:0] OFS_KIND    = 7'd4;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_COLLECT = 2'd1,
        PH_DISCARD = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_BAD_LENGTH   = 3'd1,
        ST_WRONG_TARGET = 3'd2,
        ST_BAD_CHECKSUM = 3'd3,
        ST_TRUNCATED    = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       idle_gap;
    } rx_item_t;

    typedef struct packed {
        logic [7:0] echo_byte;
        logic [6:0] byte_offset;
        logic       in_frame;
        logic       frame_end;
        logic [2:0] frame_status;
        logic [7:0] frame_kind;
        logic [7:0] source_address;
        logic [7:0] command_code;
    } rx_result_t;

endpackage

// File: hdl/length_prefixed_frame_receiver_unit.sv
`timescale 1ns / 1ps
// length-prefixed frame receiver: frame parse, target and checksum check
// depends on lpfr_pkg
// result words are registered: an accepted input word's result is in the output register the next cycle
// throughput: one input word per cycle; the only limit is the single output register
// reset: asynchronous, active low; receiver idle, host_address 0, output register empty

module length_prefixed_frame_receiver_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  lpfr_pkg::rx_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output lpfr_pkg::rx_result_t out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [7:0]           cfg_data
);

    lpfr_pkg::phase_t     phase_reg, phase_next;
    logic [7:0]           host_address_reg;
    logic [7:0]           expected_length_reg, expected_length_next;
    logic [6:0]           byte_count_reg, byte_count_next;
    logic [7:0]           running_sum_reg, running_sum_next;
    logic                 target_ok_reg, target_ok_next;
    logic [7:0]           saved_source_reg, saved_source_next;
    logic [7:0]           saved_command_reg, saved_command_next;
    logic [7:0]           saved_kind_reg, saved_kind_next;
    logic                 out_valid_reg, out_valid_next;
    lpfr_pkg::rx_result_t out_data_reg, out_data_next;

    logic                 accept;
    logic                 length_ok;
    logic                 last_byte;
    lpfr_pkg::status_t    end_status;

    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign length_ok = (in_data.rx_byte >= lpfr_pkg::MIN_LEN)
                    && (in_data.rx_byte <= lpfr_pkg::MAX_LEN)
                    && ({1'b0, in_data.rx_byte} < 9'(lpfr_pkg::MAX_FRAME));
    assign last_byte = (({1'b0, byte_count_reg}) + 8'd1) >= expected_length_reg;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (in_data.idle_gap)
        begin
            phase_next = lpfr_pkg::PH_IDLE;
        end
        else
        begin
            case (phase_reg)
                lpfr_pkg::PH_IDLE:
                begin
                    phase_next = length_ok ? lpfr_pkg::PH_COLLECT : lpfr_pkg::PH_DISCARD;
                end
                lpfr_pkg::PH_COLLECT:
                begin
                    if (last_byte)
                    begin
                        phase_next = (end_status == lpfr_pkg::ST_OK) ? lpfr_pkg::PH_IDLE
                                                                     : lpfr_pkg::PH_DISCARD;
                    end
                end
                lpfr_pkg::PH_DISCARD:
                begin
                    phase_next = lpfr_pkg::PH_DISCARD;
                end
                default:
                begin
                    phase_next = lpfr_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // datapath and result word
    always_comb
    begin
        expected_length_next = expected_length_reg;
        byte_count_next      = byte_count_reg;
        running_sum_next     = running_sum_reg;
        target_ok_next       = target_ok_reg;
        saved_source_next    = saved_source_reg;
        saved_command_next   = saved_command_reg;
        saved_kind_next      = saved_kind_reg;
        end_status           = lpfr_pkg::ST_OK;
        out_data_next        = '0;

        if (in_data.idle_gap)
        begin
            byte_count_next = '0;
            if (phase_reg == lpfr_pkg::PH_COLLECT)
            begin
                out_data_next.byte_offset    = byte_count_reg;
                out_data_next.frame_end      = 1'b1;
                out_data_next.frame_status   = lpfr_pkg::ST_TRUNCATED;
                out_data_next.frame_kind     = saved_kind_reg;
                out_data_next.source_address = saved_source_reg;
                out_data_next.command_code   = saved_command_reg;
            end
        end
        else
        begin
            out_data_next.echo_byte = in_data.rx_byte;
            case (phase_reg)
                lpfr_pkg::PH_IDLE:
                begin
                    if (length_ok)
                    begin
                        expected_length_next   = in_data.rx_byte;
                        byte_count_next        = 7'd1;
                        running_sum_next       = in_data.rx_byte;
                        target_ok_next         = 1'b0;
                        saved_source_next      = '0;
                        saved_command_next     = '0;
                        saved_kind_next        = '0;
                        out_data_next.in_frame = 1'b1;
                    end
                    else
                    begin
                        byte_count_next            = '0;
                        out_data_next.frame_end    = 1'b1;
                        out_data_next.frame_status = lpfr_pkg::ST_BAD_LENGTH;
                    end
                end
                lpfr_pkg::PH_COLLECT:
                begin
                    running_sum_next = running_sum_reg + in_data.rx_byte;
                    case (byte_count_reg)
                        lpfr_pkg::OFS_TARGET:  target_ok_next = (in_data.rx_byte == host_address_reg);
                        lpfr_pkg::OFS_SOURCE:  saved_source_next  = in_data.rx_byte;
                        lpfr_pkg::OFS_COMMAND: saved_command_next = in_data.rx_byte;
                        lpfr_pkg::OFS_KIND:    saved_kind_next    = in_data.rx_byte;
                        default:               ;
                    endcase
                    // wrong target wins over a bad sum
                    if (!target_ok_next)
                    begin
                        end_status = lpfr_pkg::ST_WRONG_TARGET;
                    end
                    else if (running_sum_next != 8'd0)
                    begin
                        end_status = lpfr_pkg::ST_BAD_CHECKSUM;
                    end
                    out_data_next.byte_offset = byte_count_reg;
                    out_data_next.in_frame    = 1'b1;
                    if (last_byte)
                    begin
                        byte_count_next              = '0;
                        out_data_next.frame_end      = 1'b1;
                        out_data_next.frame_status   = end_status;
                        out_data_next.frame_kind     = saved_kind_next;
                        out_data_next.source_address = saved_source_next;
                        out_data_next.command_code   = saved_command_next;
                    end
                    else
                    begin
                        byte_count_next = byte_count_reg + 7'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= lpfr_pkg::PH_IDLE;
            host_address_reg    <= '0;
            expected_length_reg <= '0;
            byte_count_reg      <= '0;
            running_sum_reg     <= '0;
            target_ok_reg       <= 1'b0;
            saved_source_reg    <= '0;
            saved_command_reg   <= '0;
            saved_kind_reg      <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                host_address_reg <= cfg_data;
            end
            if (accept)
            begin
                phase_reg           <= phase_next;
                expected_length_reg <= expected_length_next;
                byte_count_reg      <= byte_count_next;
                running_sum_reg     <= running_sum_next;
                target_ok_reg       <= target_ok_next;
                saved_source_reg    <= saved_source_next;
                saved_command_reg   <= saved_command_next;
                saved_kind_reg      <= saved_kind_next;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// File: hdl/lpfr_checker.sv
`timescale 1ns / 1ps
// port-level checks for the frame receiver, bound to the top level
// depends on lpfr_pkg and length_prefixed_frame_receiver_unit

module lpfr_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input lpfr_pkg::rx_result_t out_data
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // every accepted word shows up as a result next cycle
    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted word produced no result");

    // input is only held back by a full, stalled output register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    // status and header fields only on a frame end
    a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.frame_end |->
            out_data.frame_status == lpfr_pkg::ST_OK && out_data.frame_kind == 8'd0
            && out_data.source_address == 8'd0 && out_data.command_code == 8'd0)
        else $error("status or header fields set without frame end");

endmodule

bind length_prefixed_frame_receiver_unit lpfr_checker u_lpfr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// File: bench/frame_result_checker.sv
`timescale 1ns / 1ps
// result checker for the length-prefixed frame receiver: watches all three channels,
// predicts each result word and compares it field by field; depends on lpfr_pkg

module frame_result_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  lpfr_pkg::rx_item_t   in_data,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  lpfr_pkg::rx_result_t out_data,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [7:0]           cfg_data,
    output int                   mismatches,
    output int                   pending,
    output int                   results_checked
);

    lpfr_pkg::phase_t rx_phase;
    logic [7:0]       frame_len;
    logic [6:0]       bytes_seen;
    logic [7:0]       byte_sum;
    logic             target_match;
    logic [7:0]       hdr_source;
    logic [7:0]       hdr_command;
    logic [7:0]       hdr_kind;
    logic [7:0]       host_address;

    lpfr_pkg::rx_result_t expected_results[$];
    int                   fail_total    = 0;
    int                   checked_total = 0;
    int                   pending_words = 0;

    assign mismatches      = fail_total;
    assign pending         = pending_words;
    assign results_checked = checked_total;

    function automatic lpfr_pkg::rx_result_t predict_frame_result(input lpfr_pkg::rx_item_t w);
        lpfr_pkg::rx_result_t r;
        logic [6:0]           k;
        lpfr_pkg::status_t    st;
        r = '0;
        if (w.idle_gap)
        begin
            if (rx_phase == lpfr_pkg::PH_COLLECT)
            begin
                r.byte_offset    = bytes_seen;
                r.frame_end      = 1'b1;
                r.frame_status   = lpfr_pkg::ST_TRUNCATED;
                r.frame_kind     = hdr_kind;
                r.source_address = hdr_source;
                r.command_code   = hdr_command;
            end
            rx_phase   = lpfr_pkg::PH_IDLE;
            bytes_seen = '0;
        end
        else if (rx_phase == lpfr_pkg::PH_COLLECT)
        begin
            k        = bytes_seen;
            byte_sum = byte_sum + w.rx_byte;
            if (k == lpfr_pkg::OFS_TARGET)
                target_match = (w.rx_byte == host_address);
            else if (k == lpfr_pkg::OFS_SOURCE)
                hdr_source = w.rx_byte;
            else if (k == lpfr_pkg::OFS_COMMAND)
                hdr_command = w.rx_byte;
            else if (k == lpfr_pkg::OFS_KIND)
                hdr_kind = w.rx_byte;
            r.echo_byte   = w.rx_byte;
            r.byte_offset = k;
            r.in_frame    = 1'b1;
            if (int'(k) + 1 >= int'(frame_len))
            begin
                // wrong target wins over a bad checksum
                if (!target_match)
                    st = lpfr_pkg::ST_WRONG_TARGET;
                else if (byte_sum != 8'd0)
                    st = lpfr_pkg::ST_BAD_CHECKSUM;
                else
                    st = lpfr_pkg::ST_OK;
                r.frame_end      = 1'b1;
                r.frame_status   = st;
                r.frame_kind     = hdr_kind;
                r.source_address = hdr_source;
                r.command_code   = hdr_command;
                rx_phase         = (st == lpfr_pkg::ST_OK) ? lpfr_pkg::PH_IDLE
                                                           : lpfr_pkg::PH_DISCARD;
                bytes_seen       = '0;
            end
            else
            begin
                bytes_seen = k + 7'd1;
            end
        end
        else if (rx_phase == lpfr_pkg::PH_DISCARD)
        begin
            r.echo_byte = w.rx_byte;
        end
        else
        begin
            // idle: this word is a length byte
            r.echo_byte = w.rx_byte;
            if (w.rx_byte >= lpfr_pkg::MIN_LEN && w.rx_byte <= lpfr_pkg::MAX_LEN
                && int'(w.rx_byte) < lpfr_pkg::MAX_FRAME)
            begin
                frame_len    = w.rx_byte;
                bytes_seen   = 7'd1;
                byte_sum     = w.rx_byte;
                target_match = 1'b0;
                hdr_source   = '0;
                hdr_command  = '0;
                hdr_kind     = '0;
                rx_phase     = lpfr_pkg::PH_COLLECT;
                r.in_frame   = 1'b1;
            end
            else
            begin
                rx_phase       = lpfr_pkg::PH_DISCARD;
                bytes_seen     = '0;
                r.frame_end    = 1'b1;
                r.frame_status = lpfr_pkg::ST_BAD_LENGTH;
            end
        end
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_total++;
        end
    endtask

    always @(posedge clk)
    begin : track
        lpfr_pkg::rx_result_t want;
        if (!rst_n)
        begin
            rx_phase     = lpfr_pkg::PH_IDLE;
            frame_len    = '0;
            bytes_seen   = '0;
            byte_sum     = '0;
            target_match = 1'b0;
            hdr_source   = '0;
            hdr_command  = '0;
            hdr_kind     = '0;
            host_address = '0;
            expected_results.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                host_address = cfg_data;
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result word with nothing expected: %h", out_data);
                    fail_total++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("echo_byte", want.echo_byte, out_data.echo_byte);
                    compare_field("byte_offset", 8'(want.byte_offset),
                                  8'(out_data.byte_offset));
                    compare_field("in_frame", 8'(want.in_frame), 8'(out_data.in_frame));
                    compare_field("frame_end", 8'(want.frame_end), 8'(out_data.frame_end));
                    compare_field("frame_status", 8'(want.frame_status),
                                  8'(out_data.frame_status));
                    compare_field("frame_kind", want.frame_kind, out_data.frame_kind);
                    compare_field("source_address", want.source_address,
                                  out_data.source_address);
                    compare_field("command_code", want.command_code, out_data.command_code);
                    checked_total++;
                end
            end
            if (in_valid && !in_stall)
                expected_results.push_back(predict_frame_result(in_data));
        end
        pending_words <= expected_results.size();
    end

endmodule

// File: bench/tb_length_prefixed_frame_receiver_unit.sv
`timescale 1ns / 1ps
// testbench top for length_prefixed_frame_receiver_unit: frame stimulus, idling and verdict
// depends on lpfr_pkg, the receiver rtl and frame_result_checker

module tb_length_prefixed_frame_receiver_unit;

    localparam int RUN_WORDS   = 850;
    localparam int NUM_PHASES  = 6;
    localparam int STALL_LIMIT = 1000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    lpfr_pkg::rx_item_t   in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    lpfr_pkg::rx_result_t out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [7:0]           cfg_data  = '0;

    int mismatches;
    int pending;
    int results_checked;

    bit         sender_idles    = 1'b1;
    bit         sink_idles      = 1'b1;
    logic [7:0] host_addr       = '0;
    int         words_sent      = 0;
    int         good_frames     = 0;
    int         rejected_frames = 0;
    int         cut_frames      = 0;
    int         host_writes     = 0;
    int         quiet_cycles;

    initial
    begin
        forever #1 clk = ~clk;
    end

    length_prefixed_frame_receiver_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    frame_result_checker u_frame_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_data        (out_data),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .pending         (pending),
        .results_checked (results_checked)
    );

    // valid stays high across back-to-back words, it is only lowered for a random idle pause before a word
    task automatic send_rx_word(input logic [7:0] b, input logic gap);
        int n;
        n = sender_idles ? $urandom_range(0, 19) : 0;
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid         <= 1'b1;
        in_data.rx_byte  <= b;
        in_data.idle_gap <= gap;
        do @(posedge clk); while (in_stall);
        words_sent++;
    endtask

    task automatic send_gap;
        send_rx_word(8'($urandom), 1'b1);
    endtask

    task automatic wait_for_drain;
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_host(input logic [7:0] v);
        wait_for_drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        host_addr = v;
        host_writes++;
    endtask

    // builds a frame whose byte sum is zero, then breaks it as asked;
    // a rejected frame is followed by up to three discarded words and a resync gap
    task automatic send_frame(input int len, input int cut, input bit bad_target,
                              input bit bad_sum);
        logic [7:0] fb [0:119];
        logic [7:0] sum;
        int         i;
        sum   = '0;
        fb[0] = 8'(len);
        fb[1] = bad_target ? host_addr ^ 8'($urandom_range(1, 255)) : host_addr;
        for (i = 2; i < len - 1; i++)
            fb[i] = 8'($urandom_range(0, 255));
        for (i = 0; i < len - 1; i++)
            sum += fb[i];
        fb[len-1] = -sum;
        if (bad_sum)
            fb[len-1] += 8'($urandom_range(1, 255));
        for (i = 0; i < cut; i++)
            send_rx_word(fb[i], 1'b0);
        if (cut < len)
        begin
            send_gap();
            cut_frames++;
        end
        else if (bad_target || bad_sum)
        begin
            repeat ($urandom_range(0, 3)) send_rx_word(8'($urandom), 1'b0);
            send_gap();
            rejected_frames++;
        end
        else
        begin
            good_frames++;
        end
    endtask

    task automatic send_bad_length(input logic [7:0] b);
        send_rx_word(b, 1'b0);
        repeat ($urandom_range(0, 3)) send_rx_word(8'($urandom), 1'b0);
        send_gap();
        rejected_frames++;
    endtask

    task automatic send_random_sequence;
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        len  = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 120) : $urandom_range(6, 12);
        if (pick < 55)
        begin
            send_frame(len, len, 1'b0, 1'b0);
            if ($urandom_range(0, 3) == 0)
                send_gap();
        end
        else if (pick < 63)
            send_frame(len, len, 1'b1, 1'($urandom_range(0, 1)));
        else if (pick < 71)
            send_frame(len, len, 1'b0, 1'b1);
        else if (pick < 81)
            send_frame(len, $urandom_range(1, len - 1), 1'b0, 1'b0);
        else if (pick < 88)
            send_bad_length(pick[0] ? 8'($urandom_range(0, 5)) : 8'($urandom_range(121, 255)));
        else if (pick < 94)
        begin
            send_rx_word(8'($urandom), 1'b0);
            send_gap();
        end
        else
            send_gap();
    endtask

    // result side: stall drawn per word, independent of the input side; sink_idles switches it per phase
    initial
    begin : result_sink
        int n;
        forever
        begin
            n = sink_idles ? $urandom_range(0, 19) : 0;
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin : watchdog
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("run stalled for %0d cycles", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : stimulus
        logic [7:0] host_values [0:NUM_PHASES-1];
        int         p;
        int         phase_end;
        host_values = '{8'hFF, 8'h00, 8'($urandom), 8'h01, 8'hA5, 8'($urandom)};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset host address, gaps, bad lengths, discarding, header cases
        send_gap();
        send_rx_word(8'h00, 1'b0);
        send_rx_word(8'hFF, 1'b0);
        send_gap();
        send_rx_word(8'd5, 1'b0);
        send_gap();
        send_rx_word(8'd121, 1'b0);
        send_gap();
        send_rx_word(8'hFF, 1'b0);
        send_gap();
        send_frame(6, 6, 1'b0, 1'b0);
        send_frame(6, 6, 1'b1, 1'b1);
        send_frame(7, 3, 1'b0, 1'b0);

        for (p = 0; p < NUM_PHASES; p++)
        begin
            // the sender holds off here until every result word is back
            write_host(host_values[p]);
            sender_idles = (p % 4 == 0) || (p % 4 == 2);
            sink_idles   = (p % 4 == 0) || (p % 4 == 3);
            if (p == 0)
                send_frame(120, 120, 1'b0, 1'b0);
            // spread what is left of the word budget over the remaining phases
            phase_end = words_sent + (RUN_WORDS - words_sent) / (NUM_PHASES - p);
            while (words_sent < phase_end)
                send_random_sequence();
        end

        wait_for_drain();
        repeat (4) @(posedge clk);
        $display("covered %0d input words: %0d clean frames, %0d rejected, %0d cut short",
                 words_sent, good_frames, rejected_frames, cut_frames);
        $display("%0d result words compared over %0d host address settings",
                 results_checked, host_writes);
        if (mismatches == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: length_prefixed_frame_receiver_unit.f
hdl/lpfr_pkg.sv
hdl/length_prefixed_frame_receiver_unit.sv
hdl/lpfr_checker.sv
bench/frame_result_checker.sv
bench/tb_length_prefixed_frame_receiver_unit.sv
